@@ hdl/incremental_bounding_sphere_macros.svh @@
// ----------------------------------------------------------------------------
// Incremental bounding sphere assertion macros
// Short forms for clocked assertions that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INCREMENTAL_BOUNDING_SPHERE_MACROS_SVH
`define INCREMENTAL_BOUNDING_SPHERE_MACROS_SVH

// Implication checked at every rising edge of clk, off while rst_n is low.
`define IBS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication.
`define IBS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hdl/ibs_pkg.sv @@
// ----------------------------------------------------------------------------
// ibs_pkg
// Shared types and constants of the incremental bounding sphere block.
// ----------------------------------------------------------------------------
package ibs_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int RAD_W       = COORD_WIDTH - 1;
    localparam int DLT_W       = COORD_WIDTH + 1;   // difference of two coordinates
    localparam int OP_W        = COORD_WIDTH + 2;   // multiplier operand
    localparam int PROD_W      = 2 * OP_W;          // multiplier product
    localparam int MUL_HALF    = OP_W / 2;
    localparam int D2_W        = 2 * COORD_WIDTH + 2; // sum of three squares
    localparam int RR_W        = 2 * RAD_W;

    // Shift-subtract unit
    localparam int ITER_REM_W  = OP_W + 4;
    localparam int ITER_SRC_W  = PROD_W;
    localparam int ITER_RES_W  = OP_W + 2;
    localparam int DEN_W       = OP_W + 1;
    localparam int SQRT_STEPS  = ITER_SRC_W / 2;
    localparam int DIV_STEPS   = ITER_RES_W;
    localparam int ITER_CNT_W  = $clog2(DIV_STEPS);
    localparam int SUM_W       = ITER_RES_W + 2;

    localparam logic [RAD_W-1:0] RMAX = {RAD_W{1'b1}};
    localparam logic [D2_W-1:0] EPS_SQ =
        D2_W'(((64'd1 << (2 * FRAC_BITS)) + 64'd5000) / 64'd10000);

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_POINT  = 2'd1,
        CMD_SPHERE = 2'd2,
        CMD_NONE   = 2'd3
    } ibs_cmd_t;

    typedef struct packed {
        logic load;
        logic sqrt_mode;
    } ibs_iter_ctl_t;

endpackage

@@ hdl/ibs_if.sv @@
// ----------------------------------------------------------------------------
// ibs_if
// Valid/ready channels of the incremental bounding sphere block.
// ----------------------------------------------------------------------------
interface ibs_in_if import ibs_pkg::*; ();
    logic                            valid;
    logic                            ready;
    logic [1:0]                      cmd;
    logic signed [COORD_WIDTH-1:0]   pos_x;
    logic signed [COORD_WIDTH-1:0]   pos_y;
    logic signed [COORD_WIDTH-1:0]   pos_z;
    logic [RAD_W-1:0]                add_radius;

    modport source (output valid, cmd, pos_x, pos_y, pos_z, add_radius, input ready);
    modport sink   (input valid, cmd, pos_x, pos_y, pos_z, add_radius, output ready);
endinterface

interface ibs_out_if import ibs_pkg::*; ();
    logic                            valid;
    logic                            ready;
    logic signed [COORD_WIDTH-1:0]   center_x;
    logic signed [COORD_WIDTH-1:0]   center_y;
    logic signed [COORD_WIDTH-1:0]   center_z;
    logic [RAD_W-1:0]                radius;
    logic                            grew;

    modport source (output valid, center_x, center_y, center_z, radius, grew, input ready);
    modport sink   (input valid, center_x, center_y, center_z, radius, grew, output ready);
endinterface

@@ hdl/incremental_bounding_sphere.sv @@
// ----------------------------------------------------------------------------
// incremental_bounding_sphere
// Running bounding sphere in signed Q16.16, grown by points and spheres.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                                  | handshake
//  in_item   | in  | cmd, pos_x, pos_y, pos_z, add_radius     | valid/ready
//  result    | out | center_x, center_y, center_z, radius, grew | valid/ready
//
//  Clear and unused commands go straight to the output register; an item that
//  leaves the sphere alone or adopts the new sphere needs the four products and
//  the inside test. A growth step adds one square root (34 steps) and three
//  divisions (36 steps each) on the shared shift-subtract unit, plus products.
//  in_item.ready is high only while the sequencer is idle. The result sits in
//  an output register; a stalled result holds the sequencer at its last step.
//  rst_n clears the sphere to zero and empties the output register.
// ----------------------------------------------------------------------------
module incremental_bounding_sphere import ibs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    ibs_in_if.sink     in_item,
    ibs_out_if.source  result
);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_SQ_GO     = 12'b0000_0000_0010,
        S_SQ_WAIT   = 12'b0000_0000_0100,
        S_TEST      = 12'b0000_0000_1000,
        S_SQRT_GO   = 12'b0000_0001_0000,
        S_SQRT_WAIT = 12'b0000_0010_0000,
        S_K         = 12'b0000_0100_0000,
        S_KM_GO     = 12'b0000_1000_0000,
        S_KM_WAIT   = 12'b0001_0000_0000,
        S_DIV_GO    = 12'b0010_0000_0000,
        S_DIV_WAIT  = 12'b0100_0000_0000,
        S_DONE      = 12'b1000_0000_0000
    } state_t;

    localparam logic [1:0] IDX_RR   = 2'd3;   // fourth product: radius term
    localparam logic [1:0] IDX_LAST = 2'd2;   // last axis

    state_t                       state_reg, state_next;
    logic [1:0]                   idx_reg, idx_next;
    logic                         out_valid_reg;

    // sphere and item registers
    logic signed [COORD_WIDTH-1:0] c_reg   [3];
    logic [RAD_W-1:0]              r_reg;
    logic [1:0]                    cmd_reg;
    logic signed [COORD_WIDTH-1:0] p_reg   [3];
    logic [RAD_W-1:0]              ar_reg;
    logic signed [DLT_W-1:0]       dlt_reg [3];
    logic [D2_W-1:0]               d2_reg;
    logic [RR_W-1:0]               rr_reg;
    logic [OP_W-1:0]               d_reg;
    logic [OP_W-1:0]               k_reg;
    logic signed [COORD_WIDTH-1:0] nc_reg  [3];
    logic [RAD_W-1:0]              nr_reg;

    // output register
    logic signed [COORD_WIDTH-1:0] oc_reg  [3];
    logic [RAD_W-1:0]              or_reg;
    logic                          og_reg;

    // shared units
    logic                  mul_go, mul_busy;
    logic [OP_W-1:0]       mul_a, mul_b;
    logic [PROD_W-1:0]     mul_prod;
    ibs_iter_ctl_t         iter_ctl;
    logic [ITER_REM_W-1:0] iter_rem;
    logic [ITER_SRC_W-1:0] iter_src;
    logic                  iter_busy;
    logic [ITER_RES_W-1:0] iter_res;

    logic                  accept;
    logic                  out_free;
    logic [DLT_W-1:0]      mag_sel;
    logic [RAD_W-1:0]      rdiff;
    logic [D2_W-1:0]       lim;
    logic                  r_ge_ar, ar_ge_r, d2_le_rr;
    logic [OP_W-1:0]       d_raw, d_eff, s_val;
    logic [OP_W+1:0]       r_sum;
    logic signed [SUM_W-1:0] c_sum;
    logic signed [COORD_WIDTH-1:0] c_sat;
    logic                  grew_val;

    assign accept   = in_item.valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || result.ready;

    // magnitude of the difference on the current axis
    always_comb
    begin
        if (dlt_reg[idx_reg[1:0] == IDX_RR ? 2'd0 : idx_reg][DLT_W-1])
        begin
            mag_sel = DLT_W'(-dlt_reg[idx_reg == IDX_RR ? 2'd0 : idx_reg]);
        end
        else
        begin
            mag_sel = DLT_W'(dlt_reg[idx_reg == IDX_RR ? 2'd0 : idx_reg]);
        end
    end

    assign r_ge_ar = (r_reg >= ar_reg);
    assign ar_ge_r = (ar_reg >= r_reg);
    assign rdiff   = r_ge_ar ? (r_reg - ar_reg) : (ar_reg - r_reg);

    // multiplier operands: squares first, then |delta| * k per axis
    always_comb
    begin
        mul_a = OP_W'(mag_sel);
        mul_b = OP_W'(mag_sel);
        if (state_reg == S_KM_GO || state_reg == S_KM_WAIT)
        begin
            mul_b = k_reg;
        end
        else if (idx_reg == IDX_RR)
        begin
            mul_a = (cmd_reg == CMD_POINT) ? OP_W'(r_reg) : OP_W'(rdiff);
            mul_b = mul_a;
        end
    end

    assign mul_go = (state_reg == S_SQ_GO) || (state_reg == S_KM_GO);

    ibs_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (mul_go),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .prod  (mul_prod)
    );

    // square root of d2, or (|delta| * k) / (2d)
    always_comb
    begin
        iter_ctl.load      = (state_reg == S_SQRT_GO) || (state_reg == S_DIV_GO);
        iter_ctl.sqrt_mode = (state_reg == S_SQRT_GO);
        if (state_reg == S_SQRT_GO)
        begin
            iter_rem = '0;
            iter_src = ITER_SRC_W'(d2_reg);
        end
        else
        begin
            iter_rem = ITER_REM_W'(mul_prod[PROD_W-1:DIV_STEPS]);
            iter_src = {mul_prod[DIV_STEPS-1:0], (ITER_SRC_W-DIV_STEPS)'(0)};
        end
    end

    ibs_iter u_iter (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (iter_ctl),
        .init_rem (iter_rem),
        .init_src (iter_src),
        .den      ({d_reg, 1'b0}),
        .busy     (iter_busy),
        .res      (iter_res)
    );

    // inside tests
    assign lim      = D2_W'(rr_reg) + EPS_SQ;
    assign d2_le_rr = (d2_reg <= D2_W'(rr_reg));

    // distance, step length and merged radius
    always_comb
    begin
        d_raw = iter_res[OP_W-1:0];
        d_eff = d_raw;
        s_val = d_raw;
        r_sum = (OP_W+2)'(r_reg) + (OP_W+2)'(d_raw);
        if (cmd_reg == CMD_SPHERE)
        begin
            if (d_raw == '0)
            begin
                d_eff = OP_W'(1);
            end
            s_val = d_raw + OP_W'(ar_reg);
            r_sum = (OP_W+2)'(r_reg) + (OP_W+2)'(ar_reg) + (OP_W+2)'(d_eff);
        end
    end

    // moved center on the current axis, saturated
    always_comb
    begin
        if (dlt_reg[idx_reg == IDX_RR ? 2'd0 : idx_reg][DLT_W-1])
        begin
            c_sum = SUM_W'(c_reg[idx_reg == IDX_RR ? 2'd0 : idx_reg])
                    - $signed({2'b00, iter_res});
        end
        else
        begin
            c_sum = SUM_W'(c_reg[idx_reg == IDX_RR ? 2'd0 : idx_reg])
                    + $signed({2'b00, iter_res});
        end
        if (c_sum > SUM_W'(signed'({1'b0, RMAX})))
        begin
            c_sat = signed'({1'b0, RMAX});
        end
        else if (c_sum < -SUM_W'(signed'({1'b0, RMAX})) - SUM_W'(1))
        begin
            c_sat = signed'({1'b1, RAD_W'(0)});
        end
        else
        begin
            c_sat = COORD_WIDTH'(c_sum);
        end
    end

    assign grew_val = (nc_reg[0] != c_reg[0]) || (nc_reg[1] != c_reg[1])
                   || (nc_reg[2] != c_reg[2]) || (nr_reg != r_reg);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next = '0;
                    if (in_item.cmd inside {CMD_POINT, CMD_SPHERE})
                    begin
                        state_next = S_SQ_GO;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SQ_GO:     state_next = S_SQ_WAIT;
            S_SQ_WAIT:
            begin
                if (!mul_busy)
                begin
                    if (idx_reg == IDX_RR)
                    begin
                        state_next = S_TEST;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SQ_GO;
                    end
                end
            end
            S_TEST:
            begin
                if (cmd_reg == CMD_POINT)
                begin
                    state_next = (d2_reg > lim) ? S_SQRT_GO : S_DONE;
                end
                else
                begin
                    state_next = ((r_ge_ar || ar_ge_r) && d2_le_rr) ? S_DONE : S_SQRT_GO;
                end
            end
            S_SQRT_GO:   state_next = S_SQRT_WAIT;
            S_SQRT_WAIT:
            begin
                if (!iter_busy)
                begin
                    state_next = S_K;
                end
            end
            S_K:
            begin
                idx_next   = '0;
                state_next = S_KM_GO;
            end
            S_KM_GO:     state_next = S_KM_WAIT;
            S_KM_WAIT:
            begin
                if (!mul_busy)
                begin
                    state_next = S_DIV_GO;
                end
            end
            S_DIV_GO:    state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (!iter_busy)
                begin
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_KM_GO;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            c_reg[0]      <= '0;
            c_reg[1]      <= '0;
            c_reg[2]      <= '0;
            r_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (state_reg == S_DONE && out_free)
            begin
                // commit the sphere and hand the item to the output register
                out_valid_reg <= 1'b1;
                c_reg         <= nc_reg;
                r_reg         <= nr_reg;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_reg    <= in_item.cmd;
                    p_reg[0]   <= in_item.pos_x;
                    p_reg[1]   <= in_item.pos_y;
                    p_reg[2]   <= in_item.pos_z;
                    ar_reg     <= in_item.add_radius;
                    dlt_reg[0] <= DLT_W'(in_item.pos_x) - DLT_W'(c_reg[0]);
                    dlt_reg[1] <= DLT_W'(in_item.pos_y) - DLT_W'(c_reg[1]);
                    dlt_reg[2] <= DLT_W'(in_item.pos_z) - DLT_W'(c_reg[2]);
                    d2_reg     <= '0;
                    if (in_item.cmd == CMD_CLEAR)
                    begin
                        nc_reg[0] <= '0;
                        nc_reg[1] <= '0;
                        nc_reg[2] <= '0;
                        nr_reg    <= '0;
                    end
                    else
                    begin
                        nc_reg <= c_reg;
                        nr_reg <= r_reg;
                    end
                end
            end
            S_SQ_WAIT:
            begin
                if (!mul_busy)
                begin
                    if (idx_reg == IDX_RR)
                    begin
                        rr_reg <= mul_prod[RR_W-1:0];
                    end
                    else
                    begin
                        d2_reg <= d2_reg + mul_prod[D2_W-1:0];
                    end
                end
            end
            S_TEST:
            begin
                // adopt the new sphere when it encloses the current one
                if (cmd_reg == CMD_SPHERE && !(r_ge_ar && d2_le_rr) && ar_ge_r && d2_le_rr)
                begin
                    nc_reg <= p_reg;
                    nr_reg <= ar_reg;
                end
            end
            S_K:
            begin
                d_reg  <= d_eff;
                k_reg  <= (s_val > OP_W'(r_reg)) ? (s_val - OP_W'(r_reg)) : '0;
                nr_reg <= (r_sum[OP_W+1:1] > (OP_W+1)'(RMAX)) ? RMAX
                                                              : RAD_W'(r_sum[OP_W+1:1]);
            end
            S_DIV_WAIT:
            begin
                if (!iter_busy)
                begin
                    nc_reg[idx_reg] <= c_sat;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    oc_reg <= nc_reg;
                    or_reg <= nr_reg;
                    og_reg <= grew_val;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_item.ready   = (state_reg == S_IDLE);
    assign result.valid    = out_valid_reg;
    assign result.center_x = oc_reg[0];
    assign result.center_y = oc_reg[1];
    assign result.center_z = oc_reg[2];
    assign result.radius   = or_reg;
    assign result.grew     = og_reg;

endmodule

@@ hdl/ibs_mul.sv @@
// ----------------------------------------------------------------------------
// ibs_mul
// Multiplier: one half-width multiplier used on each half of b in turn.
// ----------------------------------------------------------------------------
module ibs_mul import ibs_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [OP_W-1:0]   a,
    input  logic [OP_W-1:0]   b,
    output logic              busy,
    output logic [PROD_W-1:0] prod
);

    logic                         phase_reg;
    logic [OP_W+MUL_HALF-1:0]     part_reg;
    logic [PROD_W-1:0]            prod_reg;
    logic [OP_W-MUL_HALF-1:0]     b_sel;
    logic [OP_W+MUL_HALF-1:0]     pp;

    assign b_sel = phase_reg ? b[OP_W-1:MUL_HALF] : (OP_W-MUL_HALF)'(b[MUL_HALF-1:0]);
    assign pp    = (OP_W+MUL_HALF)'(a) * (OP_W+MUL_HALF)'(b_sel);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else if (phase_reg)
        begin
            phase_reg <= 1'b0;
        end
        else if (go)
        begin
            phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && !phase_reg)
        begin
            part_reg <= pp;
        end
        if (phase_reg)
        begin
            prod_reg <= PROD_W'(part_reg) + (PROD_W'(pp) << MUL_HALF);
        end
    end

    assign busy = phase_reg;
    assign prod = prod_reg;

endmodule

@@ hdl/ibs_iter.sv @@
// ----------------------------------------------------------------------------
// ibs_iter
// Shift-subtract unit: restoring square root (two bits a step) or division.
// ----------------------------------------------------------------------------
module ibs_iter import ibs_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ibs_iter_ctl_t         ctl,
    input  logic [ITER_REM_W-1:0] init_rem,
    input  logic [ITER_SRC_W-1:0] init_src,
    input  logic [DEN_W-1:0]      den,
    output logic                  busy,
    output logic [ITER_RES_W-1:0] res
);

    logic                  busy_reg;
    logic                  mode_reg;
    logic [ITER_CNT_W-1:0] cnt_reg;
    logic [ITER_REM_W-1:0] rem_reg;
    logic [ITER_SRC_W-1:0] src_reg;
    logic [ITER_RES_W-1:0] res_reg;
    logic [ITER_REM_W-1:0] sh;
    logic [ITER_REM_W-1:0] trial;
    logic [ITER_REM_W-1:0] diff;
    logic                  ge;

    always_comb
    begin
        if (mode_reg)
        begin
            sh    = {rem_reg[ITER_REM_W-3:0], src_reg[ITER_SRC_W-1:ITER_SRC_W-2]};
            trial = {res_reg, 2'b01};
        end
        else
        begin
            sh    = {rem_reg[ITER_REM_W-2:0], src_reg[ITER_SRC_W-1]};
            trial = ITER_REM_W'(den);
        end
        ge   = (sh >= trial);
        diff = sh - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mode_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.load)
        begin
            busy_reg <= 1'b1;
            mode_reg <= ctl.sqrt_mode;
            cnt_reg  <= ctl.sqrt_mode ? ITER_CNT_W'(SQRT_STEPS - 1)
                                      : ITER_CNT_W'(DIV_STEPS - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rem_reg <= init_rem;
            src_reg <= init_src;
            res_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff : sh;
            res_reg <= {res_reg[ITER_RES_W-2:0], ge};
            src_reg <= mode_reg ? (src_reg << 2) : (src_reg << 1);
        end
    end

    assign busy = busy_reg;
    assign res  = res_reg;

endmodule

@@ hdl/ibs_checker.sv @@
// ----------------------------------------------------------------------------
// ibs_checker
// Port-level checks of the incremental bounding sphere block.
// ----------------------------------------------------------------------------
`include "incremental_bounding_sphere_macros.svh"

module ibs_checker import ibs_pkg::*; (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [COORD_WIDTH-1:0] center_x,
    input logic [RAD_W-1:0]              radius,
    input logic                          grew
);

    `IBS_ASSERT_IMPL(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

    `IBS_ASSERT_IMPL(a_out_stable, out_valid && !out_ready,
        $stable(center_x) && $stable(radius) && $stable(grew), "stalled result changed")

    `IBS_ASSERT_IMPL(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "item accepted while previous item still in work")

    `IBS_ASSERT_SAME(a_ready_known, rst_n, in_ready == 1'b0 || in_ready == 1'b1,
        "input ready undefined")

endmodule

bind incremental_bounding_sphere ibs_checker u_ibs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_ready  (in_item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .center_x  (result.center_x),
    .radius    (result.radius),
    .grew      (result.grew)
);
